FILE: rtl/core/tt_pkg.sv
// Shared types and constants for the tick timekeeper core.
// No dependencies; tt_state, tt_udiv and the core module use this package.
`timescale 1ns / 1ps
`default_nettype none
package tt_pkg;

    localparam int RATE_W  = 14;
    localparam int USEC_W  = 20;
    localparam int PROD_W  = 34;
    localparam int STEP_W  = 6;

    localparam logic [RATE_W-1:0] RATE_RESET   = 14'd100;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_READ = 2'd1,
        CMD_LOAD = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [63:0]       seconds;
        logic [RATE_W-1:0] subticks;
        logic [31:0]       tick_count;
        logic              resched_due;
        logic [31:0]       slice_left;
        logic [31:0]       kernel_ticks;
        logic [31:0]       user_ticks;
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/core/tt_if.sv
// Handshake channel interfaces for requests, results and rate configuration.
// Depends on nothing beyond the language itself.
`timescale 1ns / 1ps
`default_nettype none
interface tt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        in_kernel_mode;
    logic [31:0] slice_ticks;

    modport source (output valid, cmd, in_kernel_mode, slice_ticks, input ready);
    modport sink   (input valid, cmd, in_kernel_mode, slice_ticks, output ready);
endinterface

interface tt_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] seconds;
    logic [19:0] microseconds;
    logic [31:0] tick_count;
    logic        resched_due;
    logic [31:0] slice_left;
    logic [31:0] kernel_ticks;
    logic [31:0] user_ticks;

    modport source (output valid, seconds, microseconds, tick_count, resched_due,
                    slice_left, kernel_ticks, user_ticks, input ready);
    modport sink   (input valid, seconds, microseconds, tick_count, resched_due,
                    slice_left, kernel_ticks, user_ticks, output ready);
endinterface

interface tt_cfg_if;
    logic        valid;
    logic        ready;
    logic [13:0] tick_rate_hz;

    modport source (output valid, tick_rate_hz, input ready);
    modport sink   (input valid, tick_rate_hz, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tt_state.sv
// Timekeeping state: tick, sub-second, seconds, slice and accounting counters.
// Also holds the tick rate register. Depends on tt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tt_state (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [tt_pkg::RATE_W-1:0] i_cfg_rate,
    input  wire logic                      i_req_we,
    input  wire logic [1:0]                i_cmd,
    input  wire logic                      i_kernel,
    input  wire logic [31:0]               i_slice,
    output tt_pkg::t_state                 o_state,
    output logic [tt_pkg::RATE_W-1:0]      o_rate_eff
);

    logic [tt_pkg::RATE_W-1:0] r_rate;
    tt_pkg::t_state            r_st;
    tt_pkg::t_state            n_st;
    logic [tt_pkg::RATE_W:0]   w_sub_inc;

    assign o_rate_eff = (r_rate == '0) ? tt_pkg::RATE_W'(1) : r_rate;
    assign w_sub_inc  = {1'b0, r_st.subticks} + (tt_pkg::RATE_W+1)'(1);
    assign o_state    = r_st;

    always_comb begin
        n_st = r_st;
        if (i_req_we) begin
            case (i_cmd)
                tt_pkg::CMD_TICK: begin
                    n_st.tick_count = r_st.tick_count + 32'd1;
                    if (r_st.slice_left == '0) begin
                        n_st.resched_due = 1'b1;
                    end else begin
                        if (i_kernel) begin
                            n_st.kernel_ticks = r_st.kernel_ticks + 32'd1;
                        end else begin
                            n_st.user_ticks = r_st.user_ticks + 32'd1;
                        end
                        n_st.slice_left = r_st.slice_left - 32'd1;
                        if (r_st.slice_left == 32'd1) begin
                            n_st.resched_due = 1'b1;
                        end
                    end
                    if (w_sub_inc >= {1'b0, o_rate_eff}) begin
                        n_st.subticks = '0;
                        n_st.seconds  = r_st.seconds + 64'd1;
                    end else begin
                        n_st.subticks = w_sub_inc[tt_pkg::RATE_W-1:0];
                    end
                end
                tt_pkg::CMD_LOAD: begin
                    n_st.slice_left  = i_slice;
                    n_st.resched_due = 1'b0;
                end
                default: begin
                    n_st = r_st;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= tt_pkg::RATE_RESET;
            r_st   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_rate;
            end
            r_st <= n_st;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tt_udiv.sv
// Bit-serial restoring divider: one quotient bit per cycle, low bits kept.
// Depends on tt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tt_udiv (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [tt_pkg::PROD_W-1:0] i_dividend,
    input  wire logic [tt_pkg::RATE_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [tt_pkg::USEC_W-1:0]      o_quot
);

    logic                      r_busy;
    logic                      r_done;
    logic [tt_pkg::STEP_W-1:0] r_cnt;
    logic [tt_pkg::PROD_W-1:0] r_num;
    logic [tt_pkg::RATE_W-1:0] r_den;
    logic [tt_pkg::RATE_W-1:0] r_rem;
    logic [tt_pkg::USEC_W-1:0] r_quot;
    logic [tt_pkg::RATE_W:0]   w_trial;
    logic                      w_fit;

    assign w_trial = {r_rem, r_num[tt_pkg::PROD_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tt_pkg::STEP_W'(tt_pkg::PROD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - tt_pkg::STEP_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[tt_pkg::PROD_W-2:0], 1'b0};
            r_quot <= {r_quot[tt_pkg::USEC_W-2:0], w_fit};
            if (w_fit) begin
                r_rem <= tt_pkg::RATE_W'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= w_trial[tt_pkg::RATE_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tick_timekeeper_with_time_slice_core.sv
// Each request (tick, time read or slice load) updates the state at the edge where it is
// accepted and returns one result showing the state afterwards. The microsecond field
// comes from a bit-serial divider, one bit per cycle; a request passes from acceptance
// to the result register through a product register, a divider load, the divide steps,
// pickup of the divider's completion and the output load. A new request is accepted in
// the cycle after the previous result is loaded into the output register, so no new
// request is taken while one is in flight; a result held back by the receiver stalls
// the output load and with it the input. Rate writes are accepted at any time.
// Depends on tt_pkg, tt_if, tt_state and tt_udiv.
`timescale 1ns / 1ps
`default_nettype none
module tick_timekeeper_with_time_slice_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tt_req_if.sink    i_req,
    tt_cfg_if.sink    i_cfg,
    tt_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_fsm;

    t_fsm                      r_fsm;
    logic                      r_out_valid;
    logic                      r_start;
    logic [tt_pkg::PROD_W-1:0] r_prod;
    tt_pkg::t_state            w_st;
    logic [tt_pkg::RATE_W-1:0] w_rate;
    logic                      w_req_acc;
    logic                      w_out_free;
    logic                      w_done;
    logic [tt_pkg::USEC_W-1:0] w_quot;

    logic [63:0] r_seconds;
    logic [19:0] r_usec;
    logic [31:0] r_tick_count;
    logic        r_resched_due;
    logic [31:0] r_slice_left;
    logic [31:0] r_kernel_ticks;
    logic [31:0] r_user_ticks;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_fsm == S_IDLE);
    assign w_req_acc   = i_req.valid && (r_fsm == S_IDLE);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    tt_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_rate (i_cfg.tick_rate_hz),
        .i_req_we   (w_req_acc),
        .i_cmd      (i_req.cmd),
        .i_kernel   (i_req.in_kernel_mode),
        .i_slice    (i_req.slice_ticks),
        .o_state    (w_st),
        .o_rate_eff (w_rate)
    );

    tt_udiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_prod),
        .i_divisor  (w_rate),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= tt_pkg::PROD_W'(w_st.subticks) * tt_pkg::PROD_W'(tt_pkg::USEC_PER_SEC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
            r_start     <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_fsm)
                S_IDLE: begin
                    if (w_req_acc) begin
                        r_fsm <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_start <= 1'b1;
                    r_fsm   <= S_DIV;
                end
                S_DIV: begin
                    if (w_done) begin
                        r_fsm <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_seconds      <= w_st.seconds;
                        r_usec         <= (w_st.subticks >= w_rate) ? tt_pkg::USEC_MAX : w_quot;
                        r_tick_count   <= w_st.tick_count;
                        r_resched_due  <= w_st.resched_due;
                        r_slice_left   <= w_st.slice_left;
                        r_kernel_ticks <= w_st.kernel_ticks;
                        r_user_ticks   <= w_st.user_ticks;
                        r_fsm          <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.seconds      = r_seconds;
    assign o_rsp.microseconds = r_usec;
    assign o_rsp.tick_count   = r_tick_count;
    assign o_rsp.resched_due  = r_resched_due;
    assign o_rsp.slice_left   = r_slice_left;
    assign o_rsp.kernel_ticks = r_kernel_ticks;
    assign o_rsp.user_ticks   = r_user_ticks;

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the tick timekeeper core: tick, time read and slice load requests.
// Keeps its own timekeeper state and checks every result field in order of arrival.
// Depends on tt_pkg, the tt_if channel interfaces and tick_timekeeper_with_time_slice_core.
`timescale 1ns / 1ps
module tb;

    localparam logic [1:0]                CMD_SPARE  = 2'd3;
    localparam logic [tt_pkg::RATE_W-1:0] RATE_TOP   = {tt_pkg::RATE_W{1'b1}};
    localparam int                        CYCLE_CAP  = 1000000;
    localparam int                        SETTLE     = 40;
    localparam int                        ITEMS_EACH = 190;

    typedef struct packed {
        logic [63:0]               seconds;
        logic [tt_pkg::USEC_W-1:0] microseconds;
        logic [31:0]               tick_count;
        logic                      resched_due;
        logic [31:0]               slice_left;
        logic [31:0]               kernel_ticks;
        logic [31:0]               user_ticks;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    tt_req_if req_ch ();
    tt_cfg_if cfg_ch ();
    tt_rsp_if rsp_ch ();

    tick_timekeeper_with_time_slice_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    tt_pkg::t_state            clock_state;
    logic [tt_pkg::RATE_W-1:0] rate_hz;
    t_result                   pending_results[$];
    int                        mismatch_count;
    int                        cycle_count;
    int                        send_idle_pct;
    int                        recv_stall_pct;
    int                        hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [tt_pkg::USEC_W-1:0] usec_of(
            input logic [tt_pkg::RATE_W-1:0] sub,
            input logic [tt_pkg::RATE_W-1:0] rate);
        logic [63:0] prod;
        logic [63:0] quot;
        logic [63:0] divisor;
        divisor = (rate == '0) ? 64'd1 : 64'(rate);
        prod    = 64'(sub) * 64'(tt_pkg::USEC_PER_SEC);
        quot    = prod / divisor;
        if (quot > 64'(tt_pkg::USEC_MAX)) begin
            quot = 64'(tt_pkg::USEC_MAX);
        end
        return quot[tt_pkg::USEC_W-1:0];
    endfunction

    function automatic t_result advance_timekeeper(input logic [1:0] cmd, input logic kernel,
                                                   input logic [31:0] slice);
        t_result     res;
        logic [31:0] next_sub;
        logic [31:0] eff_rate;
        eff_rate = (rate_hz == '0) ? 32'd1 : 32'(rate_hz);
        if (cmd == tt_pkg::CMD_TICK) begin
            clock_state.tick_count += 32'd1;
            if (clock_state.slice_left == '0) begin
                clock_state.resched_due = 1'b1;
            end else begin
                if (kernel) begin
                    clock_state.kernel_ticks += 32'd1;
                end else begin
                    clock_state.user_ticks += 32'd1;
                end
                clock_state.slice_left -= 32'd1;
                if (clock_state.slice_left == '0) begin
                    clock_state.resched_due = 1'b1;
                end
            end
            next_sub = 32'(clock_state.subticks) + 32'd1;
            if (next_sub >= eff_rate) begin
                clock_state.subticks = '0;
                clock_state.seconds += 64'd1;
            end else begin
                clock_state.subticks = next_sub[tt_pkg::RATE_W-1:0];
            end
        end else if (cmd == tt_pkg::CMD_LOAD) begin
            clock_state.slice_left  = slice;
            clock_state.resched_due = 1'b0;
        end
        res.seconds      = clock_state.seconds;
        res.microseconds = usec_of(clock_state.subticks, rate_hz);
        res.tick_count   = clock_state.tick_count;
        res.resched_due  = clock_state.resched_due;
        res.slice_left   = clock_state.slice_left;
        res.kernel_ticks = clock_state.kernel_ticks;
        res.user_ticks   = clock_state.user_ticks;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    task automatic compare_result(input t_result want);
        if (rsp_ch.seconds !== want.seconds)
            report_mismatch("seconds", rsp_ch.seconds, want.seconds);
        if (rsp_ch.microseconds !== want.microseconds)
            report_mismatch("microseconds", 64'(rsp_ch.microseconds), 64'(want.microseconds));
        if (rsp_ch.tick_count !== want.tick_count)
            report_mismatch("tick_count", 64'(rsp_ch.tick_count), 64'(want.tick_count));
        if (rsp_ch.resched_due !== want.resched_due)
            report_mismatch("resched_due", 64'(rsp_ch.resched_due), 64'(want.resched_due));
        if (rsp_ch.slice_left !== want.slice_left)
            report_mismatch("slice_left", 64'(rsp_ch.slice_left), 64'(want.slice_left));
        if (rsp_ch.kernel_ticks !== want.kernel_ticks)
            report_mismatch("kernel_ticks", 64'(rsp_ch.kernel_ticks), 64'(want.kernel_ticks));
        if (rsp_ch.user_ticks !== want.user_ticks)
            report_mismatch("user_ticks", 64'(rsp_ch.user_ticks), 64'(want.user_ticks));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", 64'd0, 64'd0);
                end else begin
                    compare_result(pending_results.pop_front());
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                rate_hz = cfg_ch.tick_rate_hz;
            end
            if (req_ch.valid && req_ch.ready) begin
                pending_results.push_back(advance_timekeeper(req_ch.cmd, req_ch.in_kernel_mode,
                                                             req_ch.slice_ticks));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_req(input logic [1:0] cmd, input logic kernel, input logic [31:0] slice);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= cmd;
        req_ch.in_kernel_mode <= kernel;
        req_ch.slice_ticks    <= slice;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [tt_pkg::RATE_W-1:0] rate);
        drain_results();
        @(negedge i_clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.tick_rate_hz <= rate;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_request();
        int pick;
        logic [31:0] slice;
        pick  = $urandom_range(99);
        slice = $urandom;
        if (pick < 55) begin
            send_req(tt_pkg::CMD_TICK, 1'($urandom), slice);
        end else if (pick < 70) begin
            send_req(tt_pkg::CMD_READ, 1'($urandom), slice);
        end else if (pick < 93) begin
            if ($urandom_range(99) >= 15) begin
                slice = 32'($urandom_range(12));
            end
            send_req(tt_pkg::CMD_LOAD, 1'($urandom), slice);
        end else begin
            send_req(CMD_SPARE, 1'($urandom), slice);
        end
    endtask

    task automatic test_after_reset();
        send_req(tt_pkg::CMD_READ, 1'b0, 32'd0);
        send_req(CMD_SPARE, 1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_slice_accounting();
        send_req(tt_pkg::CMD_TICK, 1'b0, 32'd0);
        send_req(tt_pkg::CMD_TICK, 1'b1, 32'd0);
        send_req(tt_pkg::CMD_LOAD, 1'b0, 32'd0);
        send_req(tt_pkg::CMD_TICK, 1'b1, 32'd0);
        send_req(tt_pkg::CMD_LOAD, 1'b1, 32'd1);
        send_req(tt_pkg::CMD_TICK, 1'b1, 32'd0);
        send_req(tt_pkg::CMD_LOAD, 1'b0, 32'd2);
        send_req(tt_pkg::CMD_TICK, 1'b0, 32'hFFFF_FFFF);
        send_req(tt_pkg::CMD_READ, 1'b1, 32'hFFFF_FFFF);
        send_req(tt_pkg::CMD_LOAD, 1'b0, 32'hFFFF_FFFF);
        send_req(tt_pkg::CMD_TICK, 1'b1, 32'd0);
        send_req(tt_pkg::CMD_TICK, 1'b0, 32'd0);
    endtask

    task automatic test_rate_extremes();
        write_rate('0);
        send_req(tt_pkg::CMD_TICK, 1'b1, 32'd0);
        send_req(tt_pkg::CMD_TICK, 1'b0, 32'd0);
        send_req(tt_pkg::CMD_READ, 1'b0, 32'd0);
        write_rate(RATE_TOP);
        send_req(tt_pkg::CMD_TICK, 1'b0, 32'd0);
        send_req(tt_pkg::CMD_READ, 1'b0, 32'd0);
    endtask

    task automatic test_rate_lowered();
        write_rate(14'd8);
        repeat (6) send_req(tt_pkg::CMD_TICK, 1'b0, 32'd0);
        write_rate(14'd3);
        send_req(tt_pkg::CMD_READ, 1'b0, 32'd0);
        send_req(tt_pkg::CMD_TICK, 1'b1, 32'd0);
        send_req(tt_pkg::CMD_READ, 1'b0, 32'd0);
    endtask

    task automatic test_random_traffic(input logic [tt_pkg::RATE_W-1:0] rate,
                                       input int idle_pct, input int stall_pct);
        write_rate(rate);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (ITEMS_EACH) send_random_request();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_rate(14'd5);
        hold_cycles = 400;
        repeat (12) send_random_request();
    endtask

    initial begin
        i_rst_n                = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.cmd             = tt_pkg::CMD_TICK;
        req_ch.in_kernel_mode  = 1'b0;
        req_ch.slice_ticks     = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.tick_rate_hz    = tt_pkg::RATE_RESET;
        rsp_ch.ready           = 1'b0;
        clock_state            = '0;
        rate_hz                = tt_pkg::RATE_RESET;
        mismatch_count         = 0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        hold_cycles            = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_slice_accounting();
        test_rate_extremes();
        test_rate_lowered();
        test_random_traffic(14'd3, 0, 0);
        test_random_traffic(14'd10000, 60, 0);
        test_random_traffic(14'd7, 0, 60);
        test_random_traffic(14'($urandom_range(1, 40)), 38, 38);
        test_random_traffic(tt_pkg::RATE_RESET, 0, 0);
        test_backpressure();

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
